/* sv/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and fixed widths of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int U_BITS   = 30;   // normalized magnitude, msb of max at bit 29
	localparam int S_BITS   = 62;   // sum of three squares of U_BITS values
	localparam int R_BITS   = 32;   // square root result
	localparam int SQ_STEPS = 32;   // one root bit per stage
	localparam int OUT_BITS = 16;

	typedef logic [2:0][U_BITS-1:0] u_vec_t;

	typedef struct packed {
		logic [2:0] neg;    // sign of each cross product component
		logic       degen;  // cross product is the zero vector
	} side_t;

	typedef struct packed {
		side_t  side;
		u_vec_t u;
	} sq_tag_t;

endpackage

/* sv/tfn_front.sv */
// ----------------------------------------------------------------------------
// tfn_front
// Edge vectors, cross product and component magnitudes over four stages.
// ----------------------------------------------------------------------------
module tfn_front
	import tfn_pkg::*;
#(
	parameter int CB = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_in,
	input  logic signed [CB-1:0]       pa [3],
	input  logic signed [CB-1:0]       pb [3],
	input  logic signed [CB-1:0]       pc [3],
	output logic                       vld_out,
	output logic [2*CB+2:0]            mag [3],
	output side_t                      side
);

	localparam int EW = CB + 1;
	localparam int PW = 2 * EW;
	localparam int NW = PW + 1;

	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [PW-1:0] pp_s2 [6];
	logic signed [NW-1:0] n_s3  [3];
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [NW-1:0]        mag_s4 [3];
	side_t                side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(pb[i]) - EW'(pa[i]);
				e2_s1[i] <= EW'(pc[i]) - EW'(pa[i]);
			end
			pp_s2[0] <= e1_s1[1] * e2_s1[2];
			pp_s2[1] <= e1_s1[2] * e2_s1[1];
			pp_s2[2] <= e1_s1[2] * e2_s1[0];
			pp_s2[3] <= e1_s1[0] * e2_s1[2];
			pp_s2[4] <= e1_s1[0] * e2_s1[1];
			pp_s2[5] <= e1_s1[1] * e2_s1[0];
			for (int i = 0; i < 3; i++)
				n_s3[i] <= NW'(pp_s2[2*i]) - NW'(pp_s2[2*i+1]);
			for (int i = 0; i < 3; i++) begin
				mag_s4[i]       <= n_s3[i][NW-1] ? NW'(-n_s3[i]) : NW'(n_s3[i]);
				side_s4.neg[i]  <= n_s3[i][NW-1];
			end
			side_s4.degen <= (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
		end
	end

	assign vld_out = vld_s4;
	assign mag     = mag_s4;
	assign side    = side_s4;

endmodule

/* sv/tfn_norm.sv */
// ----------------------------------------------------------------------------
// tfn_norm
// Common left shift of three magnitudes until the largest has its msb on top,
// one binary shift step per stage.
// ----------------------------------------------------------------------------
module tfn_norm
	import tfn_pkg::*;
#(
	parameter int NW = 51
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [NW-1:0] mag [3],
	input  side_t         side_in,
	output logic          vld_out,
	output u_vec_t        u,
	output side_t         side_out
);

	localparam int LW = NW + U_BITS;
	localparam int K  = $clog2(NW);

	logic [LW-1:0] w_s    [K][3];
	logic          vld_s  [K];
	side_t         side_s [K];

	for (genvar k = 0; k < K; k++) begin : g_step
		localparam int SH = 1 << (K - 1 - k);
		logic [LW-1:0] src [3];
		logic          src_vld;
		side_t         src_side;
		logic [LW-1:0] orw;

		if (k == 0) begin : g_first
			for (genvar i = 0; i < 3; i++) begin : g_in
				assign src[i] = {mag[i], {U_BITS{1'b0}}};
			end
			assign src_vld  = vld_in;
			assign src_side = side_in;
		end else begin : g_next
			assign src      = w_s[k-1];
			assign src_vld  = vld_s[k-1];
			assign src_side = side_s[k-1];
		end

		assign orw = src[0] | src[1] | src[2];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= src_side;
				for (int i = 0; i < 3; i++)
					w_s[k][i] <= (orw[LW-1 -: SH] == '0) ? (src[i] << SH) : src[i];
			end
		end
	end

	assign vld_out  = vld_s[K-1];
	assign side_out = side_s[K-1];
	for (genvar i = 0; i < 3; i++) begin : g_out
		assign u[i] = w_s[K-1][i][LW-1 -: U_BITS];
	end

endmodule

/* sv/tfn_sqrt.sv */
// ----------------------------------------------------------------------------
// tfn_sqrt
// Sum of squares and integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tfn_sqrt
	import tfn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  sq_tag_t           tag_in,
	output logic              vld_out,
	output logic [R_BITS-1:0] root,
	output sq_tag_t           tag_out
);

	logic [2*U_BITS-1:0] sq_s1 [3];
	logic [S_BITS-1:0]   sum_s2;
	logic                vld_s1, vld_s2;
	sq_tag_t             tag_s1, tag_s2;

	logic [63:0] v_s   [SQ_STEPS];
	logic [63:0] r_s   [SQ_STEPS];
	logic        vld_s [SQ_STEPS];
	sq_tag_t     tag_s [SQ_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s1[i] <= tag_in.u[i] * tag_in.u[i];
			tag_s1 <= tag_in;
			sum_s2 <= S_BITS'(sq_s1[0]) + S_BITS'(sq_s1[1]) + S_BITS'(sq_s1[2]);
			tag_s2 <= tag_s1;
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [63:0] B = 64'(1) << (62 - 2 * k);
		logic [63:0] sv, sr, rb;
		logic        svld;
		sq_tag_t     stag;

		if (k == 0) begin : g_first
			assign sv   = 64'(sum_s2);
			assign sr   = '0;
			assign svld = vld_s2;
			assign stag = tag_s2;
		end else begin : g_next
			assign sv   = v_s[k-1];
			assign sr   = r_s[k-1];
			assign svld = vld_s[k-1];
			assign stag = tag_s[k-1];
		end

		assign rb = sr + B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= svld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[k] <= stag;
				if (sv >= rb) begin
					v_s[k] <= sv - rb;
					r_s[k] <= (sr >> 1) + B;
				end else begin
					v_s[k] <= sv;
					r_s[k] <= sr >> 1;
				end
			end
		end
	end

	assign vld_out = vld_s[SQ_STEPS-1];
	assign root    = r_s[SQ_STEPS-1][R_BITS-1:0];
	assign tag_out = tag_s[SQ_STEPS-1];

endmodule

/* sv/tfn_div.sv */
// ----------------------------------------------------------------------------
// tfn_div
// Rounded u * 2^NF / r for three lanes, one quotient bit per stage, then
// cap, sign and degenerate override into the output register.
// ----------------------------------------------------------------------------
module tfn_div
	import tfn_pkg::*;
#(
	parameter int NF = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic [R_BITS-1:0]   root,
	input  sq_tag_t             tag_in,
	output logic                vld_out,
	output logic [OUT_BITS-1:0] comp [3],
	output logic                degen
);

	localparam int DW   = R_BITS + NF;
	localparam int QW   = NF + 1;
	localparam int CAPI = (NF >= 15) ? 32767 : (1 << NF);
	localparam logic [QW-1:0] CAP = QW'(CAPI);

	logic [DW-1:0]       rem_s0 [3];
	logic [R_BITS-1:0]   r_s0;
	logic                vld_s0;
	side_t               side_s0;

	logic [DW-1:0]       rem_s [QW][3];
	logic [QW-1:0]       q_s   [QW][3];
	logic [R_BITS-1:0]   r_s   [QW];
	logic                vld_s [QW];
	side_t               side_s[QW];

	logic [OUT_BITS-1:0] comp_q [3];
	logic                degen_q, vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s0 <= 1'b0;
		else if (en)
			vld_s0 <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				rem_s0[i] <= (DW'(tag_in.u[i]) << NF) + DW'(root >> 1);
			r_s0    <= root;
			side_s0 <= tag_in.side;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int SH = NF - k;
		logic [DW-1:0]     srem [3];
		logic [QW-1:0]     sq   [3];
		logic [R_BITS-1:0] sr;
		logic              svld;
		side_t             sside;
		logic [DW-1:0]     d;

		if (k == 0) begin : g_first
			assign srem  = rem_s0;
			for (genvar i = 0; i < 3; i++) begin : g_q
				assign sq[i] = '0;
			end
			assign sr    = r_s0;
			assign svld  = vld_s0;
			assign sside = side_s0;
		end else begin : g_next
			assign srem  = rem_s[k-1];
			assign sq    = q_s[k-1];
			assign sr    = r_s[k-1];
			assign svld  = vld_s[k-1];
			assign sside = side_s[k-1];
		end

		assign d = DW'(sr) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= svld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]    <= sr;
				side_s[k] <= sside;
				for (int i = 0; i < 3; i++) begin
					if (srem[i] >= d) begin
						rem_s[k][i] <= srem[i] - d;
						q_s[k][i]   <= {sq[i][QW-2:0], 1'b1};
					end else begin
						rem_s[k][i] <= srem[i];
						q_s[k][i]   <= {sq[i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (en)
			vld_q <= vld_s[QW-1];
	end

	always_ff @(posedge clk) begin
		logic [QW-1:0]       qc;
		logic [OUT_BITS-1:0] m;
		if (en) begin
			degen_q <= side_s[QW-1].degen;
			for (int i = 0; i < 3; i++) begin
				qc = (q_s[QW-1][i] > CAP) ? CAP : q_s[QW-1][i];
				m  = OUT_BITS'(qc);
				if (side_s[QW-1].degen)
					comp_q[i] <= '0;
				else
					comp_q[i] <= side_s[QW-1].neg[i] ? -m : m;
			end
		end
	end

	assign vld_out = vld_q;
	assign comp    = comp_q;
	assign degen   = degen_q;

endmodule

/* sv/triangle_face_normal_unit.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle in signed Q1.14, with a degenerate flag.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry three vertices in signed fixed
// point; a transfer happens when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall carry normal_x/y/z and degenerate.
// One result per triangle, in order.
// Throughput: one triangle per cycle unless the receiver stalls; the pipeline is fully registered.
// Stages in order: front end, normalization, square root and divide. The root
// takes one bit per stage (32 stages) and the divide one quotient bit per
// stage (NORM_FRAC+1 stages).
// Reset clears every valid bit; the pipeline is empty right after reset.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing moves, is lost or repeats until out_stall drops.
// A zero cross product gives zero components with degenerate set.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit
	import tfn_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int NORM_FRAC  = 14
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] vertex_a_x,
	input  logic signed [COORD_BITS-1:0] vertex_a_y,
	input  logic signed [COORD_BITS-1:0] vertex_a_z,
	input  logic signed [COORD_BITS-1:0] vertex_b_x,
	input  logic signed [COORD_BITS-1:0] vertex_b_y,
	input  logic signed [COORD_BITS-1:0] vertex_b_z,
	input  logic signed [COORD_BITS-1:0] vertex_c_x,
	input  logic signed [COORD_BITS-1:0] vertex_c_y,
	input  logic signed [COORD_BITS-1:0] vertex_c_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OUT_BITS-1:0]   normal_x,
	output logic signed [OUT_BITS-1:0]   normal_y,
	output logic signed [OUT_BITS-1:0]   normal_z,
	output logic                         degenerate
);

	localparam int NW = 2 * COORD_BITS + 3;

	logic                  en;
	logic signed [COORD_BITS-1:0] pa [3];
	logic signed [COORD_BITS-1:0] pb [3];
	logic signed [COORD_BITS-1:0] pc [3];

	logic                  f_vld;
	logic [NW-1:0]         f_mag [3];
	side_t                 f_side;

	logic                  n_vld;
	u_vec_t                n_u;
	side_t                 n_side;
	sq_tag_t               n_tag;

	logic                  r_vld;
	logic [R_BITS-1:0]     r_root;
	sq_tag_t               r_tag;

	logic [OUT_BITS-1:0]   comp [3];

	// whole pipeline advances unless a finished result is held back
	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	assign pa[0] = vertex_a_x;
	assign pa[1] = vertex_a_y;
	assign pa[2] = vertex_a_z;
	assign pb[0] = vertex_b_x;
	assign pb[1] = vertex_b_y;
	assign pb[2] = vertex_b_z;
	assign pc[0] = vertex_c_x;
	assign pc[1] = vertex_c_y;
	assign pc[2] = vertex_c_z;

	tfn_front #(.CB(COORD_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (in_valid),
		.pa      (pa),
		.pb      (pb),
		.pc      (pc),
		.vld_out (f_vld),
		.mag     (f_mag),
		.side    (f_side)
	);

	tfn_norm #(.NW(NW)) u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (f_vld),
		.mag      (f_mag),
		.side_in  (f_side),
		.vld_out  (n_vld),
		.u        (n_u),
		.side_out (n_side)
	);

	assign n_tag.side = n_side;
	assign n_tag.u    = n_u;

	tfn_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (n_vld),
		.tag_in  (n_tag),
		.vld_out (r_vld),
		.root    (r_root),
		.tag_out (r_tag)
	);

	tfn_div #(.NF(NORM_FRAC)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (r_vld),
		.root    (r_root),
		.tag_in  (r_tag),
		.vld_out (out_valid),
		.comp    (comp),
		.degen   (degenerate)
	);

	assign normal_x = comp[0];
	assign normal_y = comp[1];
	assign normal_z = comp[2];

endmodule
